// ===== rtl/bafl_pkg.sv =====
// ----------------------------------------------------------------------------
// bafl_pkg
// shared types and codes of the first-fit buddy allocator
// ----------------------------------------------------------------------------
package bafl_pkg;

	// request codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_SIZE  = 2'd1,
		ST_NO_FIT    = 2'd2,
		ST_NOT_START = 2'd3
	} status_t;

	// per-node bits kept in the tree memory
	typedef struct packed {
		logic split;
		logic used;
	} node_bits_t;

	// memory port strobes
	typedef struct packed {
		logic rd;
		logic wr;
	} ram_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_EV,
		S_UP,
		S_SPLIT_P,
		S_SPLIT_L,
		S_SPLIT_H,
		S_MARK
	} state_t;

endpackage

// ===== rtl/bafl_node_ram.sv =====
// ----------------------------------------------------------------------------
// bafl_node_ram
// single-port tree node memory, registered read data
// ----------------------------------------------------------------------------
module bafl_node_ram #(
	parameter int DEPTH = 4096
) (
	input  logic                       clk,
	input  bafl_pkg::ram_ctl_t         ctl,
	input  logic [$clog2(DEPTH)-1:0]   addr,
	input  bafl_pkg::node_bits_t       wdata,
	output bafl_pkg::node_bits_t       rdata
);
	import bafl_pkg::*;

	node_bits_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= wdata;
		end
		if (ctl.rd) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== rtl/bafl_size_enc.sv =====
// ----------------------------------------------------------------------------
// bafl_size_enc
// request size check and round-up to a power-of-two level
// ----------------------------------------------------------------------------
module bafl_size_enc #(
	parameter int TOTAL_SIZE = 2048,
	parameter int LG_T       = $clog2(TOTAL_SIZE),
	parameter int LW         = $clog2(LG_T + 1)
) (
	input  logic [12:0]   alloc_size,
	output logic          bad,
	output logic [LW-1:0] want_lg
);
	localparam int CW = 18;

	logic [CW-1:0] size_w;

	assign size_w = CW'(alloc_size);
	assign bad    = (alloc_size == '0) || (size_w > CW'(TOTAL_SIZE));

	// smallest level whose block holds the request
	always_comb begin
		want_lg = '0;
		for (int i = LG_T; i >= 0; i--) begin
			if ((CW'(1) << i) >= size_w) begin
				want_lg = LW'(i);
			end
		end
	end

endmodule

// ===== rtl/buddy_allocator_first_fit.sv =====
// ----------------------------------------------------------------------------
// buddy_allocator_first_fit
// first-fit buddy allocator over a power-of-two pool, tree held in memory
// ----------------------------------------------------------------------------
//
//  channel   signals                                   handshake
//  --------  ----------------------------------------  ---------------------
//  request   op, alloc_size, free_offset               start && !busy
//  result    status, block_offset, block_size          done, one cycle
//
// an item is one request; one result per item, registered, in the cycle
// after the last step of the walk. the walk visits tree nodes in address
// order, each with a memory read and then an evaluate step; a skipped node
// climbs one level per up step, then steps to the next sibling. a split
// writes parent, lower and upper child in turn per level, and a final step
// marks the block. a rejected request is answered from idle without a walk.
// the single-port node memory sets the pace. reset clears only the root
// tree bits (kept in flops); children are written when their parent
// splits, so no clearing pass is needed. the result cannot be stalled.
//
module buddy_allocator_first_fit #(
	parameter int TOTAL_SIZE = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [12:0] alloc_size,
	input  logic [10:0] free_offset,
	output logic        done,
	output logic [1:0]  status,
	output logic [10:0] block_offset,
	output logic [11:0] block_size
);
	import bafl_pkg::*;

	localparam int LG_T = $clog2(TOTAL_SIZE);       // root level
	localparam int LW   = $clog2(LG_T + 1);         // level width
	localparam int OW   = LG_T + 1;                 // offset width, holds pool size
	localparam int NW   = $clog2(2 * TOTAL_SIZE);   // node index width
	localparam int CW   = 18;

	// control state
	state_t          state_q, state_d;
	logic            done_q, done_d;
	logic            root_split_q, root_split_d;
	logic            root_used_q, root_used_d;

	// walk context
	logic            op_q, op_d;
	logic [OW-1:0]   pos_q, pos_d;
	logic [LW-1:0]   want_q, want_d;
	logic [NW-1:0]   node_q, node_d;
	logic [LW-1:0]   lg_q, lg_d;
	logic [OW-1:0]   start_q, start_d;
	logic [OW-1:0]   next_q, next_d;

	// result registers
	status_t         status_q, status_d;
	logic [10:0]     boff_q, boff_d;
	logic [11:0]     bsize_q, bsize_d;

	// memory port
	ram_ctl_t        ram_ctl;
	logic [NW-1:0]   ram_addr;
	node_bits_t      ram_wdata, ram_rdata;

	// helpers
	logic            size_bad, pos_bad;
	logic [LW-1:0]   want_lg;
	node_bits_t      cur;
	logic [NW-1:0]   child_lo, child_hi;
	logic [OW-1:0]   leaf_sz, half;
	logic [LW-1:0]   lg_dn;

	bafl_size_enc #(
		.TOTAL_SIZE (TOTAL_SIZE)
	) u_size (
		.alloc_size (alloc_size),
		.bad        (size_bad),
		.want_lg    (want_lg)
	);

	bafl_node_ram #(
		.DEPTH (2 * TOTAL_SIZE)
	) u_ram (
		.clk   (clk),
		.ctl   (ram_ctl),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign pos_bad  = CW'(free_offset) >= CW'(TOTAL_SIZE);
	// root lives in flops, every other node in the memory
	assign cur      = (node_q == '0) ? node_bits_t'{root_split_q, root_used_q} : ram_rdata;
	assign child_lo = {node_q[NW-2:0], 1'b1};
	assign child_hi = child_lo + NW'(1);
	assign leaf_sz  = OW'(1) << lg_q;
	assign half     = leaf_sz >> 1;
	assign lg_dn    = lg_q - LW'(1);

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign block_offset = boff_q;
	assign block_size   = bsize_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			done_q       <= 1'b0;
			root_split_q <= 1'b0;
			root_used_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			done_q       <= done_d;
			root_split_q <= root_split_d;
			root_used_q  <= root_used_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		pos_q    <= pos_d;
		want_q   <= want_d;
		node_q   <= node_d;
		lg_q     <= lg_d;
		start_q  <= start_d;
		next_q   <= next_d;
		status_q <= status_d;
		boff_q   <= boff_d;
		bsize_q  <= bsize_d;
	end

	always_comb begin
		state_d      = state_q;
		done_d       = 1'b0;
		root_split_d = root_split_q;
		root_used_d  = root_used_q;
		op_d         = op_q;
		pos_d        = pos_q;
		want_d       = want_q;
		node_d       = node_q;
		lg_d         = lg_q;
		start_d      = start_q;
		next_d       = next_q;
		status_d     = status_q;
		boff_d       = boff_q;
		bsize_d      = bsize_q;
		ram_ctl      = '0;
		ram_addr     = node_q;
		ram_wdata    = '0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op_d    = op;
					pos_d   = OW'(free_offset);
					want_d  = want_lg;
					node_d  = '0;
					lg_d    = LW'(LG_T);
					start_d = '0;
					state_d = S_RD;
					// early rejects finish right here
					if (op == OP_ALLOC && size_bad) begin
						state_d  = S_IDLE;
						done_d   = 1'b1;
						status_d = ST_BAD_SIZE;
						boff_d   = '0;
						bsize_d  = '0;
					end else if (op == OP_FREE && pos_bad) begin
						state_d  = S_IDLE;
						done_d   = 1'b1;
						status_d = ST_NOT_START;
						boff_d   = '0;
						bsize_d  = '0;
					end
				end
			end
			S_RD: begin
				// root needs no read
				ram_ctl.rd = (node_q != '0);
				state_d    = S_EV;
			end
			S_EV: begin
				if (op_q == OP_ALLOC) begin
					if (cur.split && lg_q > want_q) begin
						// split and big enough to hold a fit below: go left
						node_d  = child_lo;
						lg_d    = lg_dn;
						state_d = S_RD;
					end else if (!cur.split && !cur.used && lg_q >= want_q) begin
						state_d = (lg_q > want_q) ? S_SPLIT_P : S_MARK;
					end else begin
						// no fit in this subtree, move on in address order
						next_d  = start_q + leaf_sz;
						state_d = S_UP;
					end
				end else begin
					if (cur.split && lg_q != '0) begin
						if (pos_q >= start_q + half) begin
							node_d  = child_hi;
							start_d = start_q + half;
						end else begin
							node_d  = child_lo;
						end
						lg_d    = lg_dn;
						state_d = S_RD;
					end else begin
						state_d  = S_IDLE;
						done_d   = 1'b1;
						boff_d   = '0;
						bsize_d  = '0;
						if (start_q != pos_q) begin
							status_d = ST_NOT_START;
						end else begin
							status_d = ST_OK;
							if (node_q == '0) begin
								root_used_d = 1'b0;
							end else begin
								ram_ctl.wr = 1'b1;
								ram_wdata  = node_bits_t'{cur.split, 1'b0};
							end
						end
					end
				end
			end
			S_UP: begin
				if (node_q == '0) begin
					// back at the root: whole pool scanned
					state_d  = S_IDLE;
					done_d   = 1'b1;
					status_d = ST_NO_FIT;
					boff_d   = '0;
					bsize_d  = '0;
				end else if (!node_q[0]) begin
					// upper child: climb to parent
					node_d = (node_q >> 1) - NW'(1);
					lg_d   = lg_q + LW'(1);
				end else begin
					// lower child: step to its sibling
					node_d  = node_q + NW'(1);
					start_d = next_q;
					state_d = S_RD;
				end
			end
			S_SPLIT_P: begin
				if (node_q == '0) begin
					root_split_d = 1'b1;
					root_used_d  = 1'b0;
				end else begin
					ram_ctl.wr = 1'b1;
					ram_wdata  = node_bits_t'{1'b1, 1'b0};
				end
				state_d = S_SPLIT_L;
			end
			S_SPLIT_L: begin
				ram_ctl.wr = 1'b1;
				ram_addr   = child_lo;
				state_d    = S_SPLIT_H;
			end
			S_SPLIT_H: begin
				ram_ctl.wr = 1'b1;
				ram_addr   = child_hi;
				node_d     = child_lo;
				lg_d       = lg_dn;
				state_d    = (lg_dn > want_q) ? S_SPLIT_P : S_MARK;
			end
			S_MARK: begin
				if (node_q == '0) begin
					root_split_d = 1'b0;
					root_used_d  = 1'b1;
				end else begin
					ram_ctl.wr = 1'b1;
					ram_wdata  = node_bits_t'{1'b0, 1'b1};
				end
				state_d  = S_IDLE;
				done_d   = 1'b1;
				status_d = ST_OK;
				boff_d   = 11'(start_q);
				bsize_d  = 12'(leaf_sz);
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/bafl_checker.sv =====
// ----------------------------------------------------------------------------
// bafl_checker
// port-level checks of the buddy allocator, bound to the top level
// ----------------------------------------------------------------------------
module bafl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [10:0] block_offset,
	input logic [11:0] block_size
);
	import bafl_pkg::*;

	// failed items carry no block
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (block_offset == '0 && block_size == '0))
		else $error("failed item carries a block");

	// granted sizes are powers of two
	a_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		(done && block_size != '0) |-> $onehot(block_size))
		else $error("granted size not a power of two");

	// blocks are aligned to their size
	a_align: assert property (@(posedge clk) disable iff (!arst_n)
		(done && block_size != '0) |->
			((12'(block_offset) & (block_size - 12'd1)) == '0))
		else $error("granted block misaligned");

	// an accepted item is either still in work or answered next cycle
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item dropped");

	// a result only follows an accept or work in progress
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result without an item");

endmodule

bind buddy_allocator_first_fit bafl_checker u_bafl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.block_offset (block_offset),
	.block_size   (block_size)
);
